// ----- sv/zlema_pkg.sv -----
package zlema_pkg;

  // Sample and history geometry (history depth must be a power of two)
  localparam int SAMPLE_BITS   = 16;
  localparam int HISTORY_DEPTH = 64;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);

  // Register widths
  localparam int PERIOD_W = 7;
  localparam int GAIN_W   = 17;
  localparam int CFG_W    = GAIN_W;
  localparam int FILL_W   = 7;

  // Arithmetic widths
  localparam int FRAC_W = 16;
  localparam int ACC_W  = 34;
  localparam int OUT_W  = 18;
  localparam int CORR_W = SAMPLE_BITS + 2;
  localparam int DIFF_W = ACC_W + 1;
  localparam int PROD_W = GAIN_W + 1 + DIFF_W;
  localparam int SUM_W  = PROD_W - FRAC_W + 1;
  localparam int RES_W  = ACC_W + 1 - FRAC_W;

  // Register indexes
  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_GAIN   = 1'b1;

  // Reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(9);
  localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(13107);
  localparam logic [GAIN_W-1:0]   GAIN_ONE   = GAIN_W'(65536);
  localparam logic [FILL_W-1:0]   FILL_MAX   = {FILL_W{1'b1}};

  // Saturation limits
  localparam logic signed [SUM_W-1:0] ACC_MAX = SUM_W'((64'sd1 <<< (ACC_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] ACC_MIN = -SUM_W'(64'sd1 <<< (ACC_W - 1));
  localparam logic signed [RES_W-1:0] OUT_MAX = RES_W'((64'sd1 <<< (OUT_W - 1)) - 1);
  localparam logic signed [RES_W-1:0] OUT_MIN = -RES_W'(64'sd1 <<< (OUT_W - 1));

  // Per-item control carried from the accept stage to the update stage
  typedef struct packed {
    logic valid;
    logic warm;  // still warming up: pass the raw sample
    logic seed;  // this item seeds the accumulator
    logic fwd;   // zero lag: past sample is the current one
  } s1_ctl_t;

endpackage

// ----- sv/zlema_hist_ram.sv -----
module zlema_hist_ram (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [zlema_pkg::HIST_AW-1:0]        wr_addr_i,
  input  logic signed [zlema_pkg::SAMPLE_BITS-1:0] wr_data_i,
  input  logic                                 re_i,
  input  logic [zlema_pkg::HIST_AW-1:0]        rd_addr_i,
  output logic signed [zlema_pkg::SAMPLE_BITS-1:0] rd_data_o
);

  logic signed [zlema_pkg::SAMPLE_BITS-1:0] mem [zlema_pkg::HISTORY_DEPTH];
  logic signed [zlema_pkg::SAMPLE_BITS-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port (old data on a same-address collision)
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/zlema_avg.sv -----
module zlema_avg (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     fire_i,
  input  zlema_pkg::s1_ctl_t                       ctl_i,
  input  logic signed [zlema_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic signed [zlema_pkg::SAMPLE_BITS-1:0] ram_data_i,
  input  logic [zlema_pkg::GAIN_W-1:0]             gain_i,
  output logic signed [zlema_pkg::OUT_W-1:0]       filtered_o
);

  logic signed [zlema_pkg::ACC_W-1:0]       acc_q, acc_d;
  logic signed [zlema_pkg::SAMPLE_BITS-1:0] past;
  logic [zlema_pkg::GAIN_W-1:0]             gain_eff;
  logic signed [zlema_pkg::CORR_W-1:0]      corr;
  logic signed [zlema_pkg::DIFF_W-1:0]      diff;
  logic signed [zlema_pkg::PROD_W-1:0]      prod;
  logic signed [zlema_pkg::PROD_W-1:0]      prod_rnd;
  logic signed [zlema_pkg::SUM_W-1:0]       sum;
  logic signed [zlema_pkg::ACC_W-1:0]       acc_upd;
  logic signed [zlema_pkg::ACC_W-1:0]       acc_seed;
  logic signed [zlema_pkg::ACC_W:0]         res_rnd;
  logic signed [zlema_pkg::RES_W-1:0]       res;
  logic signed [zlema_pkg::OUT_W-1:0]       res_sat;

  // Past sample: forwarded when lag is zero (written in the same cycle)
  assign past = ctl_i.fwd ? sample_i : ram_data_i;

  assign gain_eff = (gain_i > zlema_pkg::GAIN_ONE) ? zlema_pkg::GAIN_ONE : gain_i;

  // corrected = 2*x - past; diff = corrected<<16 - avg
  assign corr = (zlema_pkg::CORR_W'(sample_i) <<< 1) - zlema_pkg::CORR_W'(past);
  assign diff = zlema_pkg::DIFF_W'(signed'({corr, {zlema_pkg::FRAC_W{1'b0}}}))
              - zlema_pkg::DIFF_W'(acc_q);

  // delta = floor((gain*diff + half) / 2^16)
  assign prod     = $signed({1'b0, gain_eff}) * diff;
  assign prod_rnd = prod + zlema_pkg::PROD_W'(1 <<< (zlema_pkg::FRAC_W - 1));
  assign sum      = zlema_pkg::SUM_W'(acc_q)
                  + zlema_pkg::SUM_W'($signed(prod_rnd[zlema_pkg::PROD_W-1:zlema_pkg::FRAC_W]));

  // Saturate accumulator
  always_comb begin
    if (sum > zlema_pkg::ACC_MAX) begin
      acc_upd = zlema_pkg::ACC_W'(zlema_pkg::ACC_MAX);
    end else if (sum < zlema_pkg::ACC_MIN) begin
      acc_upd = zlema_pkg::ACC_W'(zlema_pkg::ACC_MIN);
    end else begin
      acc_upd = zlema_pkg::ACC_W'(sum);
    end
  end

  assign acc_seed = zlema_pkg::ACC_W'(signed'({past, {zlema_pkg::FRAC_W{1'b0}}}));

  // Round to nearest (halves up) and saturate to the output width
  assign res_rnd = (zlema_pkg::ACC_W+1)'(acc_upd)
                 + (zlema_pkg::ACC_W+1)'(1 <<< (zlema_pkg::FRAC_W - 1));
  assign res     = res_rnd[zlema_pkg::ACC_W:zlema_pkg::FRAC_W];

  always_comb begin
    if (res > zlema_pkg::OUT_MAX) begin
      res_sat = zlema_pkg::OUT_W'(zlema_pkg::OUT_MAX);
    end else if (res < zlema_pkg::OUT_MIN) begin
      res_sat = zlema_pkg::OUT_W'(zlema_pkg::OUT_MIN);
    end else begin
      res_sat = zlema_pkg::OUT_W'(res);
    end
  end

  assign filtered_o = ctl_i.warm ? zlema_pkg::OUT_W'(sample_i) : res_sat;

  // Accumulator update
  always_comb begin
    acc_d = acc_q;
    if (fire_i) begin
      if (ctl_i.seed) begin
        acc_d = acc_seed;
      end else if (!ctl_i.warm) begin
        acc_d = acc_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

// ----- sv/zero_lag_ema_filter.sv -----
// Zero-lag EMA filter for a stream of signed 16-bit samples. Each sample is
// stored in a 64-entry history RAM; the sample from lag = (period-1)/2 steps
// back is read out and the average moves toward 2*x - past by gain (Q1.16).
// Throughput is one transaction per clock cycle sustained while the output is
// not stalled. The edge that accepts an input also captures the sample and the
// registered RAM read into the update stage; when the output register can take
// a result, the update stage updates the accumulator (subtract, multiply, add
// and saturate, all combinational) and loads the output register, from which
// the result is taken. With the output stalled, one result waits in the output
// register and one in the update stage, and stall_o rises. The first lag+1
// samples are passed raw with warming_up_o set. Writing period restarts the
// warm-up; configure only while the block is idle.
module zero_lag_ema_filter (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // configuration
  input  logic                                     cfg_we_i,
  input  logic                                     cfg_idx_i,
  input  logic [zlema_pkg::CFG_W-1:0]              cfg_data_i,
  // input channel
  input  logic                                     valid_i,
  output logic                                     stall_o,
  input  logic signed [zlema_pkg::SAMPLE_BITS-1:0] sample_i,
  // output channel
  output logic                                     valid_o,
  input  logic                                     stall_i,
  output logic signed [zlema_pkg::OUT_W-1:0]       filtered_o,
  output logic                                     warming_up_o
);

  logic [zlema_pkg::PERIOD_W-1:0] period_q;
  logic [zlema_pkg::GAIN_W-1:0]   gain_q;
  logic [zlema_pkg::HIST_AW-1:0]  wp_q, wp_d;
  logic [zlema_pkg::FILL_W-1:0]   fill_q, fill_d, fill_inc;
  logic                           ready_q, ready_d;

  zlema_pkg::s1_ctl_t                       s1_q, s1_d;
  logic signed [zlema_pkg::SAMPLE_BITS-1:0] s1_x_q;

  logic                                     out_valid_q;
  logic signed [zlema_pkg::OUT_W-1:0]       out_filt_q;
  logic                                     out_warm_q;

  logic [zlema_pkg::PERIOD_W-1:0] lag_raw, lag;
  logic [zlema_pkg::HIST_AW-1:0]  rd_addr;
  logic                           seed;
  logic                           in_fire, out_ready, s1_fire;
  logic signed [zlema_pkg::SAMPLE_BITS-1:0] ram_rd;
  logic signed [zlema_pkg::OUT_W-1:0]       avg_filt;

  // Handshake
  assign out_ready = !out_valid_q || !stall_i;
  assign s1_fire   = s1_q.valid && out_ready;
  assign stall_o   = s1_q.valid && !out_ready;
  assign in_fire   = valid_i && !stall_o;

  // Lag from period, limited to the history depth
  assign lag_raw = (period_q == '0) ? '0 : ((period_q - 1'b1) >> 1);
  assign lag     = (int'(lag_raw) > zlema_pkg::HISTORY_DEPTH - 1)
                 ? zlema_pkg::PERIOD_W'(zlema_pkg::HISTORY_DEPTH - 1) : lag_raw;
  assign rd_addr = wp_q - zlema_pkg::HIST_AW'(lag);

  // Warm-up tracking
  assign fill_inc = (fill_q == zlema_pkg::FILL_MAX) ? fill_q : fill_q + 1'b1;
  assign seed     = !ready_q && ({1'b0, fill_inc} >= ({1'b0, lag} + 1'b1));

  always_comb begin
    wp_d    = wp_q;
    fill_d  = fill_q;
    ready_d = ready_q;
    if (cfg_we_i && cfg_idx_i == zlema_pkg::REG_PERIOD) begin
      fill_d  = '0;
      ready_d = 1'b0;
    end else if (in_fire) begin
      wp_d    = wp_q + 1'b1;
      fill_d  = fill_inc;
      ready_d = ready_q | seed;
    end
  end

  // Update-stage control
  always_comb begin
    s1_d = s1_q;
    if (in_fire) begin
      s1_d.valid = 1'b1;
      s1_d.warm  = !ready_q;
      s1_d.seed  = seed;
      s1_d.fwd   = (lag == '0);
    end else if (s1_fire) begin
      s1_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= zlema_pkg::PERIOD_RST;
      gain_q   <= zlema_pkg::GAIN_RST;
      wp_q     <= '0;
      fill_q   <= '0;
      ready_q  <= 1'b0;
      s1_q     <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == zlema_pkg::REG_PERIOD) begin
        period_q <= cfg_data_i[zlema_pkg::PERIOD_W-1:0];
      end
      if (cfg_we_i && cfg_idx_i == zlema_pkg::REG_GAIN) begin
        gain_q <= cfg_data_i[zlema_pkg::GAIN_W-1:0];
      end
      wp_q    <= wp_d;
      fill_q  <= fill_d;
      ready_q <= ready_d;
      s1_q    <= s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_x_q <= sample_i;
    end
  end

  // History RAM: write the new sample, read the lagged one
  zlema_hist_ram u_ram (
    .clk_i     (clk_i),
    .we_i      (in_fire),
    .wr_addr_i (wp_q),
    .wr_data_i (sample_i),
    .re_i      (in_fire),
    .rd_addr_i (rd_addr),
    .rd_data_o (ram_rd)
  );

  // Average update
  zlema_avg u_avg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (s1_fire),
    .ctl_i      (s1_q),
    .sample_i   (s1_x_q),
    .ram_data_i (ram_rd),
    .gain_i     (gain_q),
    .filtered_o (avg_filt)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_filt_q <= avg_filt;
      out_warm_q <= s1_q.warm;
    end
  end

  assign valid_o      = out_valid_q;
  assign filtered_o   = out_filt_q;
  assign warming_up_o = out_warm_q;

endmodule

// ----- sv/zlema_chk.sv -----
module zlema_chk (
  input logic                                     clk_i,
  input logic                                     rst_ni,
  input logic                                     valid_i,
  input logic                                     stall_o,
  input logic                                     valid_o,
  input logic                                     stall_i,
  input logic signed [zlema_pkg::OUT_W-1:0]       filtered_o,
  input logic                                     warming_up_o
);

  // Held output transaction stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("output valid dropped while stalled");

  // Held output transaction keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> $stable(filtered_o) && $stable(warming_up_o))
    else $error("output payload changed while stalled");

  // Raw pass-through must be a sign-extended sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && warming_up_o |->
      (filtered_o[zlema_pkg::OUT_W-1:zlema_pkg::SAMPLE_BITS-1] == '0) ||
      (filtered_o[zlema_pkg::OUT_W-1:zlema_pkg::SAMPLE_BITS-1] == '1))
    else $error("warm-up output is not a raw sample");

  // A fresh result is preceded by an accepted input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> $past(valid_i && !stall_o, 2))
    else $error("result without a matching input transaction");

endmodule

bind zero_lag_ema_filter zlema_chk u_zlema_chk (.*);

// ----- bench/zero_lag_ema_filter_test.sv -----
`timescale 1ns / 1ps

module zero_lag_ema_filter_test;

  localparam int     RANDOM_ITEMS = 1830;
  localparam int     QUIET_TAIL   = 200;
  localparam int     HOLD_OFF     = 60;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     DIR_N        = 29;
  localparam longint ACC_HI  = (64'sd1 <<< (zlema_pkg::ACC_W - 1)) - 1;
  localparam longint ACC_LO  = -(64'sd1 <<< (zlema_pkg::ACC_W - 1));
  localparam longint OUT_HI  = (64'sd1 <<< (zlema_pkg::OUT_W - 1)) - 1;
  localparam longint OUT_LO  = -(64'sd1 <<< (zlema_pkg::OUT_W - 1));
  localparam longint HALF_LSB = 64'sd1 <<< (zlema_pkg::FRAC_W - 1);

  typedef struct {
    logic signed [zlema_pkg::OUT_W-1:0] filtered;
    logic                               warm;
  } ema_res_t;

  typedef enum {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e                                kind;
    logic                                     reg_idx;
    logic [zlema_pkg::CFG_W-1:0]              reg_val;
    logic signed [zlema_pkg::SAMPLE_BITS-1:0] smp;
    bit                                       known;
    logic signed [zlema_pkg::OUT_W-1:0]       want_filt;
    logic                                     want_warm;
  } dir_row_t;

  // DUT ports
  logic                                     clk_i = 1'b0;
  logic                                     rst_ni = 1'b0;
  logic                                     cfg_we_i = 1'b0;
  logic                                     cfg_idx_i = zlema_pkg::REG_PERIOD;
  logic [zlema_pkg::CFG_W-1:0]              cfg_data_i = '0;
  logic                                     valid_i = 1'b0;
  logic                                     stall_o;
  logic signed [zlema_pkg::SAMPLE_BITS-1:0] sample_i = '0;
  logic                                     valid_o;
  logic                                     stall_i = 1'b0;
  logic signed [zlema_pkg::OUT_W-1:0]       filtered_o;
  logic                                     warming_up_o;

  // Predictor state
  logic signed [zlema_pkg::SAMPLE_BITS-1:0] hist_mem [zlema_pkg::HISTORY_DEPTH];
  logic [zlema_pkg::HIST_AW-1:0]            hist_wr = '0;
  logic [zlema_pkg::FILL_W-1:0]             fill_cnt = '0;
  bit                                       avg_ready = 1'b0;
  longint                                   avg_acc = 0;
  logic [zlema_pkg::PERIOD_W-1:0]           cur_period = zlema_pkg::PERIOD_RST;
  logic [zlema_pkg::GAIN_W-1:0]             cur_gain = zlema_pkg::GAIN_RST;

  ema_res_t ema_expected [$];
  int       errors = 0;
  int       cycles = 0;
  int       hold_cycles = 0;
  bit       tx_bursts = 1'b1;
  bit       rx_bursts = 1'b1;

  // Directed rows; expectations typed in where they follow directly
  dir_row_t dir_rows [DIR_N] = '{
    // reset settings: lag 4, raw pass-through, fifth sample seeds
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, 32767, 1, 32767, 1},
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, -32768, 1, -32768, 1},
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, 0, 1, 0, 1},
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, 1, 1, 1, 1},
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, -1, 1, -1, 1},
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, -32768, 0, 0, 0},
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, 32767, 0, 0, 0},
    '{ROW_WRITE, zlema_pkg::REG_GAIN, 65536, 0, 0, 0, 0},
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, 32767, 0, 0, 0},
    // period zero: lag 0, first sample seeds, then output tracks input
    '{ROW_WRITE, zlema_pkg::REG_PERIOD, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, 1234, 1, 1234, 1},
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, -32768, 1, -32768, 0},
    // zero gain holds the average
    '{ROW_WRITE, zlema_pkg::REG_GAIN, 0, 0, 0, 0, 0},
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, 32767, 1, -32768, 0},
    // gain above unity acts as unity
    '{ROW_WRITE, zlema_pkg::REG_GAIN, 131071, 0, 0, 0, 0},
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, 32767, 1, 32767, 0},
    // lag 1 at unity gain: output is 2*x - previous, largest swings
    '{ROW_WRITE, zlema_pkg::REG_PERIOD, 3, 0, 0, 0, 0},
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, 32767, 1, 32767, 1},
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, -32768, 1, -32768, 1},
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, 32767, 1, 98302, 0},
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, -32768, 1, -98303, 0},
    // nominal settings for period 5
    '{ROW_WRITE, zlema_pkg::REG_GAIN, 21845, 0, 0, 0, 0},
    '{ROW_WRITE, zlema_pkg::REG_PERIOD, 5, 0, 0, 0, 0},
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, 100, 0, 0, 0},
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, -200, 0, 0, 0},
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, 300, 0, 0, 0},
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, 21845, 0, 0, 0},
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, -21846, 0, 0, 0},
    '{ROW_SAMPLE, zlema_pkg::REG_PERIOD, 0, 12, 0, 0, 0}
  };

  zero_lag_ema_filter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .sample_i     (sample_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .filtered_o   (filtered_o),
    .warming_up_o (warming_up_o)
  );

  initial forever #10 clk_i = ~clk_i;

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Advance the filter model by one sample and return its output
  function automatic ema_res_t ema_predict(logic signed [zlema_pkg::SAMPLE_BITS-1:0] smp);
    ema_res_t                      r;
    int                            lag;
    logic [zlema_pkg::HIST_AW-1:0] rd_idx;
    longint                        x, past, g, corr, diff, delta, res;
    x   = longint'(smp);
    lag = (cur_period == '0) ? 0 : (int'(cur_period) - 1) / 2;
    if (lag > zlema_pkg::HISTORY_DEPTH - 1) lag = zlema_pkg::HISTORY_DEPTH - 1;

    hist_mem[hist_wr] = smp;
    hist_wr = hist_wr + 1'b1;
    if (fill_cnt != zlema_pkg::FILL_MAX) fill_cnt = fill_cnt + 1'b1;
    rd_idx = hist_wr - zlema_pkg::HIST_AW'(1) - zlema_pkg::HIST_AW'(lag);
    past   = longint'(hist_mem[rd_idx]);

    if (!avg_ready) begin
      // warm-up; the step that fills the history seeds the average
      if (int'(fill_cnt) >= lag + 1) begin
        avg_ready = 1'b1;
        avg_acc   = clip(past <<< zlema_pkg::FRAC_W, ACC_LO, ACC_HI);
      end
      res    = x;
      r.warm = 1'b1;
    end else begin
      g       = (cur_gain > zlema_pkg::GAIN_ONE) ? longint'(zlema_pkg::GAIN_ONE)
                                                 : longint'(cur_gain);
      corr    = 2 * x - past;
      diff    = (corr <<< zlema_pkg::FRAC_W) - avg_acc;
      delta   = (g * diff + HALF_LSB) >>> zlema_pkg::FRAC_W;
      avg_acc = clip(avg_acc + delta, ACC_LO, ACC_HI);
      res     = (avg_acc + HALF_LSB) >>> zlema_pkg::FRAC_W;
      r.warm  = 1'b0;
    end
    r.filtered = zlema_pkg::OUT_W'(clip(res, OUT_LO, OUT_HI));
    return r;
  endfunction

  // One input transaction, with an optional idle burst ahead of it
  task automatic send_sample(input logic signed [zlema_pkg::SAMPLE_BITS-1:0] smp,
                             input bit known,
                             input logic signed [zlema_pkg::OUT_W-1:0] want_filt,
                             input logic want_warm);
    ema_res_t pred;
    if (tx_bursts && $urandom_range(0, 7) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    valid_i  <= 1'b1;
    sample_i <= smp;
    do @(posedge clk_i); while (stall_o);
    pred = ema_predict(smp);
    if (known) begin
      pred.filtered = want_filt;
      pred.warm     = want_warm;
    end
    ema_expected.push_back(pred);
    @(negedge clk_i);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    valid_i <= 1'b0;
    while (ema_expected.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [zlema_pkg::CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == zlema_pkg::REG_PERIOD) begin
      cur_period = val[zlema_pkg::PERIOD_W-1:0];
      avg_ready  = 1'b0;
      fill_cnt   = '0;
    end else begin
      cur_gain = val[zlema_pkg::GAIN_W-1:0];
    end
    @(negedge clk_i);
  endtask

  // Main stimulus
  initial begin
    int                                       sent, phase, plen, lag, nom;
    logic [zlema_pkg::PERIOD_W-1:0]           per;
    logic [zlema_pkg::CFG_W-1:0]              gn;
    logic signed [zlema_pkg::SAMPLE_BITS-1:0] walk, smp;
    sent  = 0;
    phase = 0;
    walk  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        drain();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_sample(dir_rows[i].smp, dir_rows[i].known, dir_rows[i].want_filt,
                    dir_rows[i].want_warm);
      end
    end

    // Random phases, each with its own settings
    while (sent < RANDOM_ITEMS) begin
      drain();
      per = cur_period;
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       per = '0;
          1:       per = '1;
          2:       per = zlema_pkg::PERIOD_W'($urandom_range(64, 126));
          3:       per = zlema_pkg::PERIOD_W'($urandom_range(1, 2));
          default: per = zlema_pkg::PERIOD_W'($urandom_range(3, 20));
        endcase
        write_reg(zlema_pkg::REG_PERIOD, zlema_pkg::CFG_W'(per));
      end
      nom = ((1 << (zlema_pkg::FRAC_W + 1)) + (int'(per) + 1) / 2) / (int'(per) + 1);
      if (nom > (1 << zlema_pkg::GAIN_W) - 1) nom = (1 << zlema_pkg::GAIN_W) - 1;
      case ($urandom_range(0, 9))
        0:       gn = '0;
        1:       gn = zlema_pkg::CFG_W'(1);
        2:       gn = zlema_pkg::GAIN_ONE;
        3:       gn = '1;
        4:       gn = zlema_pkg::CFG_W'($urandom_range(0, (1 << zlema_pkg::GAIN_W) - 1));
        default: gn = zlema_pkg::CFG_W'(nom);
      endcase
      write_reg(zlema_pkg::REG_GAIN, gn);

      lag  = (per == '0) ? 0 : (int'(per) - 1) / 2;
      plen = lag + $urandom_range(20, 80);
      rx_bursts = (RANDOM_ITEMS - sent > QUIET_TAIL);
      tx_bursts = rx_bursts && phase != 2;
      if (phase == 2) begin
        // receiver holds off while the sender keeps going
        plen        = HOLD_OFF + 40;
        hold_cycles = HOLD_OFF;
      end

      repeat (plen) begin
        case ($urandom_range(0, 9))
          0:       smp = {1'b0, {(zlema_pkg::SAMPLE_BITS - 1){1'b1}}};
          1:       smp = {1'b1, {(zlema_pkg::SAMPLE_BITS - 1){1'b0}}};
          2:       smp = zlema_pkg::SAMPLE_BITS'($urandom_range(0, 64))
                       - zlema_pkg::SAMPLE_BITS'(32);
          3, 4, 5: begin
            walk = walk + zlema_pkg::SAMPLE_BITS'($urandom_range(0, 2048))
                 - zlema_pkg::SAMPLE_BITS'(1024);
            smp  = walk;
          end
          default: smp = zlema_pkg::SAMPLE_BITS'($urandom);
        endcase
        send_sample(smp, 1'b0, '0, 1'b0);
        sent++;
      end
      phase++;
    end

    drain();
    repeat (10) @(negedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Output side: long hold-off on request, otherwise random stall bursts
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        stall_i <= 1'b1;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
        stall_i <= 1'b0;
      end else if (rx_bursts && $urandom_range(0, 7) == 0) begin
        stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
        stall_i <= 1'b0;
      end
    end
  end

  // Compare each output transaction with the oldest expectation
  always @(posedge clk_i) begin
    ema_res_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (ema_expected.size() == 0) begin
        $error("unexpected result: filtered %0d, warming_up %0b", filtered_o, warming_up_o);
        errors++;
      end else begin
        want = ema_expected.pop_front();
        if (filtered_o !== want.filtered) begin
          $error("filtered: expected %0d, actual %0d", want.filtered, filtered_o);
          errors++;
        end
        if (warming_up_o !== want.warm) begin
          $error("warming_up: expected %0b, actual %0b", want.warm, warming_up_o);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
